// File: sv/dmaseg_pkg.sv
`timescale 1ns / 1ps

package dmaseg_pkg;

   // field widths of the request, result and control beats
   localparam int WRITE_W       = 1;
   localparam int TOTAL_W       = 21;
   localparam int FOFF_W        = 63;
   localparam int DOFF_W        = 40;
   localparam int BASE_W        = 16;
   localparam int CIDX_W        = 24;
   localparam int COFF_W        = 30;
   localparam int TICKET_W      = 64;
   localparam int PAGES_W       = 15;

   // defaults and limits
   localparam int PAGE_BYTES_DEF    = 65536;
   localparam int MAX_REQUEST_BYTES = 1048576;
   localparam int CHUNK_PAGES_MAX   = 16384;

   localparam logic [PAGES_W-1:0]  CHUNK_PAGES_RESET = 15'd32;
   localparam logic [TICKET_W-1:0] TICKET_RESET      = 64'd500;

endpackage

// File: sv/dmaseg_chan_if.sv
`timescale 1ns / 1ps

// request channel: one transfer per beat
interface dmaseg_req_if;
   logic                                valid;
   logic                                ready;
   logic [dmaseg_pkg::WRITE_W-1:0]      is_write;
   logic [dmaseg_pkg::TOTAL_W-1:0]      total_size;
   logic [dmaseg_pkg::FOFF_W-1:0]       file_offset;
   logic [dmaseg_pkg::DOFF_W-1:0]       dev_offset;
   logic [dmaseg_pkg::BASE_W-1:0]       base_page_offset;

   modport source (output valid, is_write, total_size, file_offset, dev_offset,
                   base_page_offset, input ready);
   modport sink   (input valid, is_write, total_size, file_offset, dev_offset,
                   base_page_offset, output ready);
endinterface

// result channel: one segment descriptor per beat
interface dmaseg_rsp_if;
   logic                                valid;
   logic                                ready;
   logic [dmaseg_pkg::WRITE_W-1:0]      seg_write;
   logic [dmaseg_pkg::CIDX_W-1:0]       chunk_index;
   logic [dmaseg_pkg::COFF_W-1:0]       chunk_offset;
   logic [dmaseg_pkg::TOTAL_W-1:0]      seg_size;
   logic [dmaseg_pkg::FOFF_W-1:0]       seg_file_offset;
   logic [dmaseg_pkg::TICKET_W-1:0]     ticket;
   logic                                error;
   logic                                last;

   modport source (output valid, seg_write, chunk_index, chunk_offset, seg_size,
                   seg_file_offset, ticket, error, last, input ready);
   modport sink   (input valid, seg_write, chunk_index, chunk_offset, seg_size,
                   seg_file_offset, ticket, error, last, output ready);
endinterface

// control register write channel: chunk size in pages
interface dmaseg_csr_if;
   logic                                valid;
   logic                                ready;
   logic [dmaseg_pkg::PAGES_W-1:0]      data;

   modport source (output valid, data, input ready);
   modport sink   (input valid, data, output ready);
endinterface

// File: sv/dmaseg_divider.sv
`timescale 1ns / 1ps

// Restoring divider, one quotient bit per cycle.
// Divisor must stay stable until done.
module dmaseg_divider #(
   parameter int NUM_W = 24,
   parameter int DEN_W = 15
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [NUM_W-1:0] dividend,
   input  logic [DEN_W-1:0] divisor,
   output logic             done,
   output logic [NUM_W-1:0] quotient,
   output logic [DEN_W-1:0] remainder
);

   localparam int CNT_W = $clog2(NUM_W + 1);

   logic [NUM_W-1:0] quot_ff, quot_in;
   logic [DEN_W-1:0] rem_ff, rem_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             busy_ff, busy_in;
   logic             done_ff, done_in;

   logic [DEN_W:0]   trial;
   logic [DEN_W:0]   diff;
   logic             fits;

   // one trial subtraction per step
   always_comb begin
      trial = {rem_ff, quot_ff[NUM_W-1]};
      diff  = trial - {1'b0, divisor};
      fits  = (trial >= {1'b0, divisor});
   end

   always_comb begin
      quot_in  = quot_ff;
      rem_in   = rem_ff;
      count_in = count_ff;
      busy_in  = busy_ff;
      done_in  = 1'b0;
      if (start) begin
         quot_in  = dividend;
         rem_in   = '0;
         count_in = '0;
         busy_in  = 1'b1;
      end else if (busy_ff) begin
         quot_in  = {quot_ff[NUM_W-2:0], fits};
         rem_in   = fits ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
         count_in = count_ff + 1'b1;
         if (count_ff == CNT_W'(NUM_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      quot_ff  <= quot_in;
      rem_ff   <= rem_in;
      count_ff <= count_in;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign done      = done_ff;
   assign quotient  = quot_ff;
   assign remainder = rem_ff;

endmodule

// File: sv/dma_request_segmenter_core.sv
`timescale 1ns / 1ps

// DMA request segmenter.
// req_chan takes one transfer request per beat; rsp_chan gives one segment
// descriptor per beat, split at registration chunk boundaries and, where
// base_page_offset plus the chunk offset is not page aligned, at page
// boundaries. csr_chan writes the chunk size in pages (0 acts as 1, above
// 16384 saturates); it is always ready and must only be written while the
// block is idle.
// A request is checked in the cycle after acceptance. A zero-length
// request then ends with no beat; a too-long or overflowing request gives a
// single error beat. Otherwise the chunk index is found by the iterative
// divider, after which segments leave at one per cycle while the receiver
// does not stall; req_chan.ready is high only while idle.
// The last beat sits in the output register while the next request is taken.
// When the receiver stalls, the current beat holds and the sequencer waits.
// Reset (synchronous) empties the output register, returns to idle, sets the
// ticket counter to 500 and the chunk size to 32 pages.
module dma_request_segmenter_core #(
   parameter int PAGE_BYTES = dmaseg_pkg::PAGE_BYTES_DEF
) (
   input  logic          clock,
   input  logic          reset,
   dmaseg_req_if.sink    req_chan,
   dmaseg_rsp_if.source  rsp_chan,
   dmaseg_csr_if.sink    csr_chan
);

   localparam int PS    = $clog2(PAGE_BYTES);
   localparam int NUM_W = dmaseg_pkg::DOFF_W - PS;
   localparam int PW    = dmaseg_pkg::PAGES_W;
   localparam int CB_W  = PS + PW;
   localparam int TW    = dmaseg_pkg::TOTAL_W;
   localparam logic [PS:0] PAGE_VAL = (PS + 1)'(PAGE_BYTES);

   localparam logic [2:0] S_IDLE  = 3'd0;
   localparam logic [2:0] S_CHECK = 3'd1;
   localparam logic [2:0] S_ERR   = 3'd2;
   localparam logic [2:0] S_DIV   = 3'd3;
   localparam logic [2:0] S_SEG   = 3'd4;

   logic [2:0] state_ff, state_in;

   // control register
   logic [PW-1:0] chunk_pages_ff;
   logic [PW-1:0] pages_eff;

   // request held while it is segmented
   logic                            wr_ff;
   logic [TW-1:0]                   total_ff, total_in;
   logic [dmaseg_pkg::FOFF_W-1:0]   foff_ff, foff_in;
   logic [dmaseg_pkg::DOFF_W-1:0]   doff_ff;
   logic [PS-1:0]                   base_ff;
   logic [PW-1:0]                   pages_ff;
   logic [dmaseg_pkg::CIDX_W-1:0]   cidx_ff, cidx_in;
   logic [CB_W-1:0]                 coff_ff, coff_in;
   logic [dmaseg_pkg::TICKET_W-1:0] ticket_ff, ticket_in;

   // output register
   logic                            rsp_valid_ff, rsp_valid_in;
   logic                            o_write_ff;
   logic [dmaseg_pkg::CIDX_W-1:0]   o_cidx_ff;
   logic [dmaseg_pkg::COFF_W-1:0]   o_coff_ff;
   logic [TW-1:0]                   o_size_ff;
   logic [dmaseg_pkg::FOFF_W-1:0]   o_foff_ff;
   logic [dmaseg_pkg::TICKET_W-1:0] o_ticket_ff;
   logic                            o_error_ff;
   logic                            o_last_ff;

   logic                            load_seg, load_err, out_free;
   logic                            accept, div_start, div_done;
   logic [NUM_W-1:0]                div_quot;
   logic [PW-1:0]                   div_rem;

   logic                            too_long;
   logic [dmaseg_pkg::TICKET_W-1:0] end_sum;
   logic                            bad_req;

   logic [CB_W-1:0]                 chunk_bytes, room, coff_sum;
   logic [PS-1:0]                   va_off;
   logic [PS:0]                     page_room;
   logic [TW-1:0]                   io_chunk, io;

   assign accept       = req_chan.valid && (state_ff == S_IDLE);
   assign req_chan.ready = (state_ff == S_IDLE);
   assign csr_chan.ready = 1'b1;
   assign out_free     = !rsp_valid_ff || rsp_chan.ready;

   // chunk size with zero and over-range codes folded in
   always_comb begin
      pages_eff = chunk_pages_ff;
      if (chunk_pages_ff == '0) begin
         pages_eff = PW'(1);
      end else if (chunk_pages_ff > PW'(dmaseg_pkg::CHUNK_PAGES_MAX)) begin
         pages_eff = PW'(dmaseg_pkg::CHUNK_PAGES_MAX);
      end
   end

   // length and file range check
   always_comb begin
      too_long = (32'(total_ff) > dmaseg_pkg::MAX_REQUEST_BYTES);
      end_sum  = 64'(foff_ff) + 64'(total_ff);
      bad_req  = too_long || end_sum[63];
   end

   // segment length: chunk room, then page room where unaligned
   always_comb begin
      chunk_bytes = {pages_ff, PS'(0)};
      room        = chunk_bytes - coff_ff;
      io_chunk    = (CB_W'(total_ff) > room) ? room[TW-1:0] : total_ff;
      va_off      = base_ff + coff_ff[PS-1:0];
      page_room   = PAGE_VAL - {1'b0, va_off};
      io          = io_chunk;
      if ((va_off != '0) && (io_chunk > TW'(page_room))) begin
         io = TW'(page_room);
      end
      coff_sum    = coff_ff + CB_W'(io);
   end

   // sequencer
   always_comb begin
      state_in  = state_ff;
      div_start = 1'b0;
      load_seg  = 1'b0;
      load_err  = 1'b0;
      total_in  = total_ff;
      foff_in   = foff_ff;
      cidx_in   = cidx_ff;
      coff_in   = coff_ff;
      ticket_in = ticket_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               state_in = S_CHECK;
               total_in = req_chan.total_size;
               foff_in  = req_chan.file_offset;
            end
         end
         S_CHECK: begin
            if (total_ff == '0) begin
               state_in = S_IDLE;
            end else if (bad_req) begin
               state_in = S_ERR;
            end else begin
               div_start = 1'b1;
               state_in  = S_DIV;
            end
         end
         S_ERR: begin
            if (out_free) begin
               load_err = 1'b1;
               state_in = S_IDLE;
            end
         end
         S_DIV: begin
            if (div_done) begin
               cidx_in  = dmaseg_pkg::CIDX_W'(div_quot);
               coff_in  = {div_rem, doff_ff[PS-1:0]};
               state_in = S_SEG;
            end
         end
         S_SEG: begin
            if (out_free) begin
               load_seg  = 1'b1;
               total_in  = total_ff - io;
               foff_in   = foff_ff + dmaseg_pkg::FOFF_W'(io);
               ticket_in = ticket_ff + 1'b1;
               if (coff_sum == chunk_bytes) begin
                  coff_in = '0;
                  cidx_in = cidx_ff + 1'b1;
               end else begin
                  coff_in = coff_sum;
               end
               if (total_ff == io) begin
                  state_in = S_IDLE;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // output valid
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (load_seg || load_err) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= S_IDLE;
         rsp_valid_ff   <= 1'b0;
         ticket_ff      <= dmaseg_pkg::TICKET_RESET;
         chunk_pages_ff <= dmaseg_pkg::CHUNK_PAGES_RESET;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         ticket_ff    <= ticket_in;
         if (csr_chan.valid) begin
            chunk_pages_ff <= csr_chan.data;
         end
      end
   end

   // request and working registers
   always_ff @(posedge clock) begin
      total_ff <= total_in;
      foff_ff  <= foff_in;
      cidx_ff  <= cidx_in;
      coff_ff  <= coff_in;
      if (accept) begin
         wr_ff    <= req_chan.is_write;
         doff_ff  <= req_chan.dev_offset;
         base_ff  <= PS'(req_chan.base_page_offset);
         pages_ff <= pages_eff;
      end
   end

   // result beat
   always_ff @(posedge clock) begin
      if (load_seg) begin
         o_write_ff  <= wr_ff;
         o_cidx_ff   <= cidx_ff;
         o_coff_ff   <= dmaseg_pkg::COFF_W'(coff_ff);
         o_size_ff   <= io;
         o_foff_ff   <= foff_ff;
         o_ticket_ff <= ticket_ff;
         o_error_ff  <= 1'b0;
         o_last_ff   <= (total_ff == io);
      end else if (load_err) begin
         o_write_ff  <= wr_ff;
         o_cidx_ff   <= '0;
         o_coff_ff   <= '0;
         o_size_ff   <= '0;
         o_foff_ff   <= foff_ff;
         o_ticket_ff <= '0;
         o_error_ff  <= 1'b1;
         o_last_ff   <= 1'b1;
      end
   end

   assign rsp_chan.valid           = rsp_valid_ff;
   assign rsp_chan.seg_write       = o_write_ff;
   assign rsp_chan.chunk_index     = o_cidx_ff;
   assign rsp_chan.chunk_offset    = o_coff_ff;
   assign rsp_chan.seg_size        = o_size_ff;
   assign rsp_chan.seg_file_offset = o_foff_ff;
   assign rsp_chan.ticket          = o_ticket_ff;
   assign rsp_chan.error           = o_error_ff;
   assign rsp_chan.last            = o_last_ff;

   // page number / chunk pages gives chunk index and page within the chunk
   dmaseg_divider #(
      .NUM_W (NUM_W),
      .DEN_W (PW)
   ) u_divider (
      .clock     (clock),
      .reset     (reset),
      .start     (div_start),
      .dividend  (doff_ff[dmaseg_pkg::DOFF_W-1:PS]),
      .divisor   (pages_ff),
      .done      (div_done),
      .quotient  (div_quot),
      .remainder (div_rem)
   );

endmodule

// File: sv/dmaseg_checker.sv
`timescale 1ns / 1ps

module dmaseg_checker (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   input  logic                                req_ready,
   input  logic                                rsp_valid,
   input  logic                                rsp_ready,
   input  logic                                rsp_error,
   input  logic                                rsp_last,
   input  logic [dmaseg_pkg::TOTAL_W-1:0]      rsp_seg_size,
   input  logic [dmaseg_pkg::TICKET_W-1:0]     rsp_ticket
);

   // a stalled beat holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_ticket))
      else $error("stalled result beat changed");

   // error beat closes the request and carries no segment
   a_err_beat: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_error |-> rsp_last && (rsp_seg_size == '0) && (rsp_ticket == '0))
      else $error("malformed error beat");

   // a segment is never empty
   a_seg_size: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_error |-> (rsp_seg_size != '0))
      else $error("empty segment");

   // busy straight after taking a request
   a_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("ready after accepting a request");

   // reset leaves the block idle and empty
   a_reset: assert property (@(posedge clock)
      reset |=> !rsp_valid && req_ready)
      else $error("not idle after reset");

endmodule

bind dma_request_segmenter_core dmaseg_checker u_checker (
   .clock        (clock),
   .reset        (reset),
   .req_valid    (req_chan.valid),
   .req_ready    (req_chan.ready),
   .rsp_valid    (rsp_chan.valid),
   .rsp_ready    (rsp_chan.ready),
   .rsp_error    (rsp_chan.error),
   .rsp_last     (rsp_chan.last),
   .rsp_seg_size (rsp_chan.seg_size),
   .rsp_ticket   (rsp_chan.ticket)
);
